### rtl/core/cdr_pkg.sv
package cdr_pkg;

	localparam int OUT_W      = 32;
	localparam int TALLY_W    = 20;
	localparam int ACC_W      = 64;
	localparam int SPACE_W    = 32;
	localparam int DZ_W       = SPACE_W + 1;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int ROWS_W     = 11;
	localparam int COLS_W     = 11;
	localparam int GHOST_W    = 4;
	localparam int POS_CMP_W  = 14;
	localparam int CAP_EXP    = 62;
	localparam int ROOT_W     = ACC_W / 2;

	localparam logic [ROWS_W-1:0]  ROWS_RESET  = 11'd64;
	localparam logic [COLS_W-1:0]  COLS_RESET  = 11'd64;
	localparam logic [GHOST_W-1:0] GHOST_RESET = 4'd2;
	localparam logic [SPACE_W-1:0] SPACE_RESET = 32'd65536;

	typedef enum logic [2:0] {
		REG_ROWS  = 3'd0,
		REG_COLS  = 3'd1,
		REG_GHOST = 3'd2,
		REG_DR    = 3'd3,
		REG_DZ    = 3'd4
	} cfg_reg_t;

endpackage

### rtl/core/cdr_sample_if.sv
interface cdr_sample_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] br_sample;
	logic signed [SAMPLE_WIDTH-1:0] bz_sample;

	modport source (output valid, output br_sample, output bz_sample, input ready);
	modport sink (input valid, input br_sample, input bz_sample, output ready);
endinterface

### rtl/core/cdr_result_if.sv
interface cdr_result_if import cdr_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   rms_value;
	logic [TALLY_W-1:0] interior_cells;

	modport source (output valid, output rms_value, output interior_cells, input ready);
	modport sink (input valid, input rms_value, input interior_cells, output ready);
endinterface

### rtl/core/cdr_line_ram.sv
module cdr_line_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/cdr_divider.sv
module cdr_divider #(
	parameter int DW = 64,
	parameter int VW = 44
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quo,
	output logic [VW-1:0] rem
);
	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    den_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q && start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

### rtl/core/cdr_isqrt.sv
module cdr_isqrt import cdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  radicand,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);
	logic             busy_q;
	logic [ACC_W-1:0] bit_q;
	logic [ACC_W-1:0] v_q;
	logic [ACC_W-1:0] res_q;
	logic [ACC_W-1:0] trial;
	logic             ge;

	assign trial = res_q + bit_q;
	assign ge    = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (!busy_q && start) begin
			busy_q <= 1'b1;
			bit_q  <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			bit_q <= bit_q >> 2;
			if (bit_q == ACC_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			v_q   <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			v_q   <= ge ? v_q - trial : v_q;
			res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
		end
	end

	assign busy = busy_q;
	assign root = res_q[ROOT_W-1:0];
endmodule

### rtl/core/cylindrical_divergence_rms.sv
// channel   role    payload                        request when
// samples   sink    br_sample, bz_sample           valid & ready
// results   source  rms_value, interior_cells      valid & ready
// config    APB     five registers at 4*index      psel & penable & pwrite
//
// One request at a time: interior cells wait on the 64-step bit-serial radial
// divider on top of the sequencing states, which border cells take alone. The
// last cell of a frame adds the mean divide, the square root and the states
// that start the root and present the result.
// Line stores need no clearing after reset. A result waiting on results
// holds samples only when the next frame ends.
module cylindrical_divergence_rms import cdr_pkg::*; #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_ROWS     = 1024,
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	cdr_sample_if.sink            samples,
	cdr_result_if.source          results
);
	localparam int SW   = SAMPLE_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CW   = $clog2(MAX_COLS);
	localparam int AW   = $clog2(2 * MAX_COLS);
	localparam int JW   = ((RW > 4) ? RW : 4) + 2;
	localparam int FW   = RW + 1;
	localparam int PW   = FW + 1 + SW;
	localparam int NW   = PW + 1;
	localparam int DENW = FW + SPACE_W;
	localparam int QRW  = NW + F;
	localparam int DWA  = (QRW > ACC_W) ? QRW : ACC_W;
	localparam int VWA  = (DENW > TALLY_W) ? DENW : TALLY_W;
	localparam int AXW  = SW + 1;
	localparam int DWB  = AXW + F;
	localparam int VWB  = DZ_W;
	localparam int XA   = (DWA + 1 > CAP_EXP + 1) ? DWA + 1 : CAP_EXP + 1;
	localparam int XB   = (DWB + 1 > CAP_EXP + 1) ? DWB + 1 : CAP_EXP + 1;
	localparam int QSW  = CAP_EXP + 2;
	localparam int SUMW = CAP_EXP + 3;

	typedef enum logic [4:0] {
		S_IDLE, S_RD1, S_RD2, S_RD3, S_MUL, S_SUB, S_DGO, S_DIV,
		S_RND, S_ADD, S_SQR, S_ACC, S_STEP, S_MEAN, S_MWT, S_RWT, S_OUT
	} state_t;

	state_t state_q;

	logic [ROWS_W-1:0]  rows_q;
	logic [COLS_W-1:0]  cols_q;
	logic [GHOST_W-1:0] ghost_q;
	logic [SPACE_W-1:0] dr_q;
	logic [SPACE_W-1:0] dz_q;

	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [ACC_W-1:0]   sum_q;
	logic [TALLY_W-1:0] tally_q;
	logic               interior_q;
	logic               res_valid_q;
	logic [OUT_W-1:0]   res_rms_q;
	logic [TALLY_W-1:0] res_cells_q;

	logic signed [SW-1:0]  br_q, bz_q, bm_q, zp_q, zm_q;
	logic signed [PW-1:0]  pa_q, pb_q;
	logic [DENW-1:0]       den_rad_q;
	logic signed [AXW-1:0] axn_q;
	logic [VWB-1:0]        den_ax_q;
	logic [NW-1:0]         rmag_q;
	logic                  rneg_q;
	logic [AXW-1:0]        amag_q;
	logic                  aneg_q;
	logic signed [QSW-1:0] rad_q, axi_q;
	logic [OUT_W-1:0]      dmag_q;
	logic [ACC_W-1:0]      sq_q;
	logic [OUT_W-1:0]      rms_q;

	// configuration port
	logic     cfg_wr;
	cfg_reg_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RESET;
			cols_q  <= COLS_RESET;
			ghost_q <= GHOST_RESET;
			dr_q    <= SPACE_RESET;
			dz_q    <= SPACE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ROWS:  rows_q  <= pwdata[ROWS_W-1:0];
				REG_COLS:  cols_q  <= pwdata[COLS_W-1:0];
				REG_GHOST: ghost_q <= pwdata[GHOST_W-1:0];
				REG_DR:    dr_q    <= pwdata[SPACE_W-1:0];
				REG_DZ:    dz_q    <= pwdata[SPACE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ROWS:  prdata = CFG_DATA_W'(rows_q);
			REG_COLS:  prdata = CFG_DATA_W'(cols_q);
			REG_GHOST: prdata = CFG_DATA_W'(ghost_q);
			REG_DR:    prdata = CFG_DATA_W'(dr_q);
			REG_DZ:    prdata = CFG_DATA_W'(dz_q);
			default:   prdata = '0;
		endcase
	end

	// effective sizes and spacings
	logic [POS_CMP_W-1:0] rows_ext, cols_ext, rows_eff, cols_eff;
	logic [POS_CMP_W-1:0] row_ext, col_ext;
	logic [SPACE_W-1:0]   dr_eff, dz_eff;

	always_comb begin
		rows_ext = POS_CMP_W'(rows_q);
		cols_ext = POS_CMP_W'(cols_q);
		if (rows_ext < POS_CMP_W'(3)) begin
			rows_eff = POS_CMP_W'(3);
		end else if (rows_ext > POS_CMP_W'(MAX_ROWS)) begin
			rows_eff = POS_CMP_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_ext;
		end
		if (cols_ext < POS_CMP_W'(3)) begin
			cols_eff = POS_CMP_W'(3);
		end else if (cols_ext > POS_CMP_W'(MAX_COLS)) begin
			cols_eff = POS_CMP_W'(MAX_COLS);
		end else begin
			cols_eff = cols_ext;
		end
		row_ext = POS_CMP_W'(row_q);
		col_ext = POS_CMP_W'(col_q);
		dr_eff  = (dr_q == '0) ? SPACE_W'(1) : dr_q;
		dz_eff  = (dz_q == '0) ? SPACE_W'(1) : dz_q;
	end

	logic in_accept, is_interior, row_end, frame_end, out_free;

	assign samples.ready = (state_q == S_IDLE);
	assign in_accept     = samples.valid && samples.ready;
	assign is_interior   = (row_q >= RW'(2)) && (col_q >= CW'(1))
		&& (col_ext + POS_CMP_W'(2) <= cols_eff);
	assign row_end       = col_ext + POS_CMP_W'(1) >= cols_eff;
	assign frame_end     = row_end && (row_ext + POS_CMP_W'(1) >= rows_eff);
	assign out_free      = !res_valid_q || results.ready;

	// line stores: the half picked by row parity holds two rows back
	logic [AW-1:0] cur_addr, prev_base, bz_raddr;
	logic [SW-1:0] br_rdata, bz_rdata;

	assign cur_addr  = (row_q[0] ? AW'(MAX_COLS) : AW'(0)) + AW'(col_q);
	assign prev_base = row_q[0] ? AW'(0) : AW'(MAX_COLS);
	assign bz_raddr  = (state_q == S_RD1) ? prev_base + AW'(col_q) + AW'(1)
		: prev_base + AW'(col_q) - AW'(1);

	cdr_line_ram #(.DATA_W(SW), .DEPTH(2 * MAX_COLS)) u_br_ram (
		.clk   (clk),
		.we    (state_q == S_RD3),
		.waddr (cur_addr),
		.wdata (br_q),
		.re    (state_q == S_RD1),
		.raddr (cur_addr),
		.rdata (br_rdata)
	);

	cdr_line_ram #(.DATA_W(SW), .DEPTH(2 * MAX_COLS)) u_bz_ram (
		.clk   (clk),
		.we    (state_q == S_RD3),
		.waddr (cur_addr),
		.wdata (bz_q),
		.re    ((state_q == S_RD1) || (state_q == S_RD2)),
		.raddr (bz_raddr),
		.rdata (bz_rdata)
	);

	// radial factors
	logic signed [JW-1:0] j_s;
	logic                 jpos;
	logic [FW-1:0]        j_u, fa, fb, fd;

	always_comb begin
		j_s  = $signed({{(JW - RW){1'b0}}, row_q}) - $signed(JW'(1))
			- $signed({{(JW - GHOST_W){1'b0}}, ghost_q});
		jpos = !j_s[JW-1];
		j_u  = j_s[FW-1:0];
		fa   = jpos ? j_u + FW'(1) : FW'(1);
		fb   = jpos ? j_u : FW'(1);
		fd   = jpos ? (j_u << 1) + FW'(1) : FW'(2);
	end

	logic signed [NW-1:0] num_rad;
	logic [NW-1:0]        rmag_c;
	logic [AXW-1:0]       amag_c;

	assign num_rad = pa_q - pb_q;
	assign rmag_c  = num_rad[NW-1] ? NW'(-num_rad) : NW'(num_rad);
	assign amag_c  = axn_q[AXW-1] ? AXW'(-axn_q) : AXW'(axn_q);

	// dividers and root
	logic           start_a, start_b, start_s;
	logic [DWA-1:0] dvd_a, quo_a;
	logic [VWA-1:0] dvs_a, rem_a;
	logic [DWB-1:0] quo_b;
	logic [VWB-1:0] rem_b;
	logic           busy_a, busy_b, busy_s;
	logic [ROOT_W-1:0] root;

	assign start_a = (state_q == S_DGO) || ((state_q == S_MEAN) && (tally_q != '0));
	assign start_b = (state_q == S_DGO);
	assign start_s = (state_q == S_MWT) && !busy_a;
	assign dvd_a   = (state_q == S_MEAN) ? DWA'(sum_q) : DWA'({rmag_q, {F{1'b0}}});
	assign dvs_a   = (state_q == S_MEAN) ? VWA'(tally_q) : VWA'(den_rad_q);

	cdr_divider #(.DW(DWA), .VW(VWA)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_a),
		.dividend (dvd_a),
		.divisor  (dvs_a),
		.busy     (busy_a),
		.quo      (quo_a),
		.rem      (rem_a)
	);

	cdr_divider #(.DW(DWB), .VW(VWB)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_b),
		.dividend ({amag_q, {F{1'b0}}}),
		.divisor  (den_ax_q),
		.busy     (busy_b),
		.quo      (quo_b),
		.rem      (rem_b)
	);

	cdr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_s),
		.radicand (quo_a[ACC_W-1:0]),
		.busy     (busy_s),
		.root     (root)
	);

	// rounding half away from zero, magnitude capped
	logic [XA-1:0]        qa_x;
	logic [XB-1:0]        qb_x;
	logic [CAP_EXP:0]     qa_c, qb_c;
	logic signed [SUMW-1:0] dsum;
	logic [SUMW-1:0]      dabs;
	logic [ACC_W:0]       acc_sum;

	always_comb begin
		qa_x = XA'(quo_a) + XA'({rem_a, 1'b0} >= {1'b0, VWA'(den_rad_q)});
		qb_x = XB'(quo_b) + XB'({rem_b, 1'b0} >= {1'b0, den_ax_q});
		qa_c = (qa_x > (XA'(1) << CAP_EXP)) ? (CAP_EXP + 1)'(1) << CAP_EXP
			: qa_x[CAP_EXP:0];
		qb_c = (qb_x > (XB'(1) << CAP_EXP)) ? (CAP_EXP + 1)'(1) << CAP_EXP
			: qb_x[CAP_EXP:0];
		dsum = SUMW'(rad_q) + SUMW'(axi_q);
		dabs = dsum[SUMW-1] ? SUMW'(-dsum) : SUMW'(dsum);
		acc_sum = {1'b0, sum_q} + {1'b0, sq_q};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			sum_q       <= '0;
			tally_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && results.ready && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= interior_q ? S_MUL : S_STEP;
				S_MUL: state_q <= S_SUB;
				S_SUB: state_q <= S_DGO;
				S_DGO: state_q <= S_DIV;
				S_DIV: begin
					if (!busy_a && !busy_b) begin
						state_q <= S_RND;
					end
				end
				S_RND: state_q <= S_ADD;
				S_ADD: state_q <= S_SQR;
				S_SQR: state_q <= S_ACC;
				S_ACC: begin
					sum_q   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
					tally_q <= (tally_q == '1) ? tally_q : tally_q + TALLY_W'(1);
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (!row_end) begin
						col_q   <= col_q + CW'(1);
						state_q <= S_IDLE;
					end else begin
						col_q <= '0;
						if (!frame_end) begin
							row_q   <= row_q + RW'(1);
							state_q <= S_IDLE;
						end else begin
							row_q   <= '0;
							state_q <= S_MEAN;
						end
					end
				end
				S_MEAN: state_q <= (tally_q == '0) ? S_OUT : S_MWT;
				S_MWT: begin
					if (!busy_a) begin
						state_q <= S_RWT;
					end
				end
				S_RWT: begin
					if (!busy_s) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						sum_q       <= '0;
						tally_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					br_q       <= samples.br_sample;
					bz_q       <= samples.bz_sample;
					interior_q <= is_interior;
				end
			end
			S_RD2: begin
				bm_q <= br_rdata;
				zp_q <= bz_rdata;
			end
			S_RD3: zm_q <= bz_rdata;
			S_MUL: begin
				pa_q      <= $signed({1'b0, fa}) * br_q;
				pb_q      <= $signed({1'b0, fb}) * bm_q;
				den_rad_q <= fd * dr_eff;
				axn_q     <= zp_q - zm_q;
				den_ax_q  <= {dz_eff, 1'b0};
			end
			S_SUB: begin
				rmag_q <= rmag_c;
				rneg_q <= num_rad[NW-1];
				amag_q <= amag_c;
				aneg_q <= axn_q[AXW-1];
			end
			S_RND: begin
				rad_q <= rneg_q ? -$signed(QSW'(qa_c)) : $signed(QSW'(qa_c));
				axi_q <= aneg_q ? -$signed(QSW'(qb_c)) : $signed(QSW'(qb_c));
			end
			S_ADD: dmag_q <= (dabs > SUMW'({OUT_W{1'b1}})) ? '1 : dabs[OUT_W-1:0];
			S_SQR: sq_q <= dmag_q * dmag_q;
			S_MEAN: rms_q <= '0;
			S_RWT: begin
				if (!busy_s) begin
					rms_q <= root[OUT_W-1:0];
				end
			end
			S_OUT: begin
				if (out_free) begin
					res_rms_q   <= rms_q;
					res_cells_q <= tally_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid          = res_valid_q;
	assign results.rms_value      = res_rms_q;
	assign results.interior_cells = res_cells_q;
endmodule

### rtl/core/cdr_checker.sv
module cdr_checker import cdr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [OUT_W-1:0]      rms_value,
	input logic [TALLY_W-1:0]    interior_cells,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	input logic [CFG_DATA_W-1:0] prdata
);
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rms_value)
			&& $stable(interior_cells))
		else $error("result changed while stalled");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in flight");

	a_empty_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && interior_cells == '0 |-> rms_value == '0)
		else $error("nonzero rms with no interior cells");

	a_rows_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == {REG_ROWS, 2'b00}
			|=> paddr != {REG_ROWS, 2'b00}
				|| prdata[ROWS_W-1:0] == $past(pwdata[ROWS_W-1:0]))
		else $error("row count register lost a write");
endmodule

bind cylindrical_divergence_rms cdr_checker u_cdr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.rms_value      (results.rms_value),
	.interior_cells (results.interior_cells),
	.psel           (psel),
	.penable        (penable),
	.pwrite         (pwrite),
	.paddr          (paddr),
	.pwdata         (pwdata),
	.prdata         (prdata)
);
